// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file refers to this package by scoped names.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 32;
    localparam int PRIO_W      = 4;
    localparam int PORT_TAG_W  = 32;
    localparam int OCC_PORT_W  = 5;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [PRIO_W-1:0]    t_prio;
    typedef logic [TAG_WIDTH-1:0] t_tag;
    typedef logic [OCC_W-1:0]     t_occ;

    // One queue slot.
    typedef struct packed {
        logic  valid;
        t_prio prio;
        t_tag  tag;
    } t_entry;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic  push;
        logic  pop;
        t_prio prio;
        t_tag  tag;
    } t_cmd;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of QUEUE_DEPTH slot cells.
// A result strobes on o_done in the cycle after its command beat is accepted.
// Throughput: one beat per cycle; every cell compares against the command in parallel.
// Reset: synchronous active-low i_rst_n empties the queue and clears the strobe.
// The receiver cannot stall; busy is never raised.
module sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [3:0]  i_priority_req,
    input  logic [31:0] i_tag,
    output logic        o_done,
    output logic        o_out_valid,
    output logic [3:0]  o_out_priority,
    output logic [31:0] o_out_tag,
    output logic        o_was_empty,
    output logic        o_overflow,
    output logic [4:0]  o_occupancy
);

    localparam int D = spq_pkg::QUEUE_DEPTH;

    // Neighbor links: entries and the "stays ahead" flags of every cell.
    spq_pkg::t_entry w_entry [D];
    logic            w_le    [D];
    spq_pkg::t_cmd   w_cmd;

    logic accept;
    logic full;
    logic empty;

    logic           r_done;
    logic           r_out_valid;
    spq_pkg::t_prio r_out_prio;
    spq_pkg::t_tag  r_out_tag;
    logic           r_was_empty;
    logic           r_overflow;
    spq_pkg::t_occ  r_occ;
    spq_pkg::t_occ  n_occ;

    // Every command finishes in the cycle it is accepted, so the queue is always ready.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The valid slots form a prefix, so the ends of the chain tell full and empty.
    assign full  = w_entry[D-1].valid;
    assign empty = !w_entry[0].valid;

    // Dropped pushes and pops of an empty queue leave every cell untouched.
    always_comb begin
        w_cmd.push = accept && (i_operation == spq_pkg::OP_PUSH) && !full;
        w_cmd.pop  = accept && (i_operation == spq_pkg::OP_POP) && !empty;
        w_cmd.prio = i_priority_req;
        w_cmd.tag  = spq_pkg::TAG_WIDTH'(i_tag);
    end

    // The head cell sees an always-ahead predecessor, so a push that beats it lands
    // in slot 0; the tail cell shifts in an empty slot on a pop.
    for (genvar g = 0; g < D; g++) begin : g_cell
        spq_pkg::t_entry prev_e;
        spq_pkg::t_entry next_e;
        logic            prev_le;

        if (g == 0) begin : g_head
            assign prev_e  = '0;
            assign prev_le = 1'b1;
        end else begin : g_mid
            assign prev_e  = w_entry[g-1];
            assign prev_le = w_le[g-1];
        end

        if (g == D - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_body
            assign next_e = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_prev_le (prev_le),
            .i_prev    (prev_e),
            .i_next    (next_e),
            .o_le      (w_le[g]),
            .o_entry   (w_entry[g])
        );
    end

    // Occupancy tracks the valid prefix length.
    always_comb begin
        n_occ = r_occ;
        if (w_cmd.push) begin
            n_occ = r_occ + 1'b1;
        end else if (w_cmd.pop) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_occ  <= '0;
        end else begin
            r_done <= accept;
            r_occ  <= n_occ;
        end
    end

    // Result payload: the head entry on a successful pop, zeros otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_valid <= w_cmd.pop;
            r_out_prio  <= w_cmd.pop ? w_entry[0].prio : '0;
            r_out_tag   <= w_cmd.pop ? w_entry[0].tag : '0;
            r_was_empty <= (i_operation == spq_pkg::OP_POP) && empty;
            r_overflow  <= (i_operation == spq_pkg::OP_PUSH) && full;
        end
    end

    assign o_done         = r_done;
    assign o_out_valid    = r_out_valid;
    assign o_out_priority = r_out_prio;
    assign o_out_tag      = spq_pkg::PORT_TAG_W'(r_out_tag);
    assign o_was_empty    = r_was_empty;
    assign o_overflow     = r_overflow;
    assign o_occupancy    = spq_pkg::OCC_PORT_W'(r_occ);

endmodule

// ===== sv/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and trades with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  logic           i_prev_le,
    input  spq_pkg::t_entry i_prev,
    input  spq_pkg::t_entry i_next,
    output logic           o_le,
    output spq_pkg::t_entry o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // This slot stays ahead of the new entry when it is valid and not larger.
    assign o_le    = r_entry.valid && (r_entry.prio <= i_cmd.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.push && !o_le) begin
            if (i_prev_le) begin
                n_entry.valid = 1'b1;
                n_entry.prio  = i_cmd.prio;
                n_entry.tag   = i_cmd.tag;
            end else begin
                n_entry = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.prio <= n_entry.prio;
        r_entry.tag  <= n_entry.tag;
    end

endmodule
